### hw/rtl/stateful_flow_firewall_with_aging_defines.svh
`ifndef STATEFUL_FLOW_FIREWALL_WITH_AGING_DEFINES_SVH
`define STATEFUL_FLOW_FIREWALL_WITH_AGING_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define SFFA_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SFFA_ASSERT_NX(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/sffa_pkg.sv
`timescale 1ns / 1ps
package sffa_pkg;
	localparam int FLOW_SLOTS = 65536;
	localparam int SLOT_W = $clog2(FLOW_SLOTS);
	localparam int BKT_W = SLOT_W + 1;
	localparam int BUCKETS = 2 * FLOW_SLOTS;
	localparam int KEY_W = 96;
	localparam int TIME_W = 63;
	localparam logic [31:0] TIMEOUT_RESET = 32'd1000000000;

	localparam logic [1:0] VERDICT_DROP = 2'd0;
	localparam logic [1:0] VERDICT_LAN = 2'd1;
	localparam logic [1:0] VERDICT_WAN = 2'd2;

	typedef logic [SLOT_W-1:0] slot_t;
	// msb set means no slot
	typedef logic [SLOT_W:0] ptr_t;
	typedef logic [BKT_W-1:0] bkt_t;
	localparam ptr_t NULL_PTR = {1'b1, {SLOT_W{1'b0}}};

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [31:0] ports;
	} key_t;

	typedef struct packed {
		logic is_wan;
		logic ok;
		key_t key;
		logic [TIME_W-1:0] now;
	} item_t;

	function automatic bkt_t flow_hash(key_t k);
		bkt_t h;
		logic [KEY_W-1:0] v;
		h = '0;
		v = k;
		for (int i = 0; i < KEY_W; i++) h[i % BKT_W] = h[i % BKT_W] ^ v[i];
		return h;
	endfunction
endpackage

### hw/rtl/sffa_ifs.sv
`timescale 1ns / 1ps
interface sffa_pkt_if;
	logic valid;
	logic ready;
	logic from_wan;
	logic l4_valid;
	logic [31:0] src_ip;
	logic [31:0] dst_ip;
	logic [15:0] src_l4_port;
	logic [15:0] dst_l4_port;
	logic [62:0] now_ns;
	modport source(output valid, from_wan, l4_valid, src_ip, dst_ip, src_l4_port,
		dst_l4_port, now_ns, input ready);
	modport sink(input valid, from_wan, l4_valid, src_ip, dst_ip, src_l4_port,
		dst_l4_port, now_ns, output ready);
endinterface

interface sffa_verdict_if;
	logic valid;
	logic ready;
	logic [1:0] verdict;
	modport source(output valid, verdict, input ready);
	modport sink(input valid, verdict, output ready);
endinterface

### hw/rtl/stateful_flow_firewall_with_aging.sv
`timescale 1ns / 1ps
// an invalid packet is dropped without a lookup, a valid one is compared with its bucket
// chain one entry at a time; first the oldest flows are age checked in turn and each
// expired one is unlinked by walking its chain; packets are handled one at a time, the
// next once the verdict is registered, which can wait on res.ready; a 2-entry queue buffers
// packets; reset: async, clears control state, then all 2 * FLOW_SLOTS buckets with
// pkt.ready low; configuration writes are taken during the clearing pass
module stateful_flow_firewall_with_aging (
	input logic clk,
	input logic arst_n,
	sffa_pkt_if.sink pkt,
	sffa_verdict_if.source res,
	input logic cfg_we,
	input logic [31:0] cfg_wdata
);
	import sffa_pkg::*;

	item_t q_item;
	logic q_vld, q_pop, clr_done;

	sffa_front u_front (
		.clk(clk), .arst_n(arst_n), .pkt(pkt), .clr_done(clr_done),
		.q_item(q_item), .q_vld(q_vld), .q_pop(q_pop)
	);

	sffa_back u_back (
		.clk(clk), .arst_n(arst_n), .q_item(q_item), .q_vld(q_vld), .q_pop(q_pop),
		.clr_done(clr_done), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .res(res)
	);
endmodule

### hw/rtl/sffa_ram.sv
`timescale 1ns / 1ps
module sffa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/sffa_front.sv
`timescale 1ns / 1ps
module sffa_front (
	input logic clk,
	input logic arst_n,
	sffa_pkt_if.sink pkt,
	input logic clr_done,
	output sffa_pkg::item_t q_item,
	output logic q_vld,
	input logic q_pop
);
	import sffa_pkg::*;

	item_t buf_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	item_t cls;
	logic push;

	// wan traffic is looked up with the tuple turned around
	always_comb begin
		cls.is_wan = pkt.from_wan;
		cls.ok = pkt.l4_valid;
		cls.now = pkt.now_ns;
		if (pkt.from_wan) begin
			cls.key.src = pkt.dst_ip;
			cls.key.dst = pkt.src_ip;
			cls.key.ports = {pkt.dst_l4_port, pkt.src_l4_port};
		end else begin
			cls.key.src = pkt.src_ip;
			cls.key.dst = pkt.dst_ip;
			cls.key.ports = {pkt.src_l4_port, pkt.dst_l4_port};
		end
	end

	assign pkt.ready = (cnt_q != 2'd2) && clr_done;
	assign push = pkt.valid && pkt.ready;
	assign q_vld = (cnt_q != 2'd0);
	assign q_item = buf_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wr_q] <= cls;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end
endmodule

### hw/rtl/sffa_back.sv
`timescale 1ns / 1ps
module sffa_back (
	input logic clk,
	input logic arst_n,
	input sffa_pkg::item_t q_item,
	input logic q_vld,
	output logic q_pop,
	output logic clr_done,
	input logic cfg_we,
	input logic [31:0] cfg_wdata,
	sffa_verdict_if.source res
);
	import sffa_pkg::*;

	typedef enum logic [4:0] {
		S_CLR, S_IDLE, S_EXP_CHK, S_EXP_WAIT, S_RM_HEAD, S_RM_WALK, S_LOOK, S_LK_HEAD,
		S_LK_CMP, S_HIT, S_RF_UNLINK, S_MISS, S_AL_POP, S_AL_WR, S_AP1, S_AP2, S_OUT
	} state_t;

	state_t st_q;
	item_t item_q;
	logic [TIME_W-1:0] limit_q;
	logic can_exp_q;
	bkt_t hb_q, vb_q, clr_q;
	slot_t vic_q, cur_q, slot_q;
	ptr_t vnext_q, head_q, oldest_q, newest_q;
	logic [1:0] verdict_q;
	logic [SLOT_W:0] fcount_q, fresh_q;
	logic [31:0] timeout_q;
	logic out_vld_q;
	logic [1:0] out_verdict_q;

	logic key_we, seen_we, nxt_we, prv_we, chn_we, bkt_we, stk_we;
	slot_t key_wa, seen_wa, nxt_wa, prv_wa, chn_wa, stk_wa;
	slot_t key_ra, seen_ra, nxt_ra, prv_ra, chn_ra, stk_ra;
	bkt_t bkt_wa, bkt_ra;
	key_t key_wd, key_rd;
	logic [TIME_W-1:0] seen_wd, seen_rd;
	ptr_t nxt_wd, nxt_rd, prv_wd, prv_rd, chn_wd, chn_rd, bkt_wd, bkt_rd;
	slot_t stk_wd, stk_rd;

	logic release_now;
	logic [TIME_W-1:0] tmo_ext;
	logic [SLOT_W:0] fdec;

	assign tmo_ext = {{(TIME_W-32){1'b0}}, timeout_q};
	assign release_now = (seen_rd < limit_q);
	assign fdec = fcount_q - 1'b1;
	assign q_pop = (st_q == S_IDLE) && q_vld;
	assign clr_done = (st_q != S_CLR);
	assign res.valid = out_vld_q;
	assign res.verdict = out_verdict_q;

	sffa_ram #(.WIDTH(KEY_W), .DEPTH(FLOW_SLOTS)) u_key (.clk(clk), .we(key_we),
		.waddr(key_wa), .wdata(key_wd), .raddr(key_ra), .rdata(key_rd));
	sffa_ram #(.WIDTH(TIME_W), .DEPTH(FLOW_SLOTS)) u_seen (.clk(clk), .we(seen_we),
		.waddr(seen_wa), .wdata(seen_wd), .raddr(seen_ra), .rdata(seen_rd));
	sffa_ram #(.WIDTH(SLOT_W+1), .DEPTH(FLOW_SLOTS)) u_nxt (.clk(clk), .we(nxt_we),
		.waddr(nxt_wa), .wdata(nxt_wd), .raddr(nxt_ra), .rdata(nxt_rd));
	sffa_ram #(.WIDTH(SLOT_W+1), .DEPTH(FLOW_SLOTS)) u_prv (.clk(clk), .we(prv_we),
		.waddr(prv_wa), .wdata(prv_wd), .raddr(prv_ra), .rdata(prv_rd));
	sffa_ram #(.WIDTH(SLOT_W+1), .DEPTH(FLOW_SLOTS)) u_chn (.clk(clk), .we(chn_we),
		.waddr(chn_wa), .wdata(chn_wd), .raddr(chn_ra), .rdata(chn_rd));
	sffa_ram #(.WIDTH(SLOT_W+1), .DEPTH(BUCKETS)) u_bkt (.clk(clk), .we(bkt_we),
		.waddr(bkt_wa), .wdata(bkt_wd), .raddr(bkt_ra), .rdata(bkt_rd));
	sffa_ram #(.WIDTH(SLOT_W), .DEPTH(FLOW_SLOTS)) u_stk (.clk(clk), .we(stk_we),
		.waddr(stk_wa), .wdata(stk_wd), .raddr(stk_ra), .rdata(stk_rd));

	always_comb begin
		key_we = 1'b0; seen_we = 1'b0; nxt_we = 1'b0; prv_we = 1'b0;
		chn_we = 1'b0; bkt_we = 1'b0; stk_we = 1'b0;
		key_wa = slot_q; seen_wa = slot_q; nxt_wa = slot_q; prv_wa = slot_q;
		chn_wa = slot_q; stk_wa = fcount_q[SLOT_W-1:0]; bkt_wa = hb_q;
		key_wd = item_q.key; seen_wd = item_q.now; nxt_wd = NULL_PTR; prv_wd = NULL_PTR;
		chn_wd = head_q; bkt_wd = {1'b0, slot_q}; stk_wd = vic_q;
		key_ra = cur_q; seen_ra = cur_q; nxt_ra = cur_q; prv_ra = cur_q;
		chn_ra = cur_q; stk_ra = fdec[SLOT_W-1:0]; bkt_ra = hb_q;
		case (st_q)
			S_CLR: begin
				bkt_we = 1'b1;
				bkt_wa = clr_q;
				bkt_wd = NULL_PTR;
			end
			S_EXP_CHK: begin
				seen_ra = oldest_q[SLOT_W-1:0];
				key_ra = oldest_q[SLOT_W-1:0];
				nxt_ra = oldest_q[SLOT_W-1:0];
			end
			S_EXP_WAIT: begin
				bkt_ra = flow_hash(key_rd);
				chn_ra = vic_q;
				if (release_now) begin
					if (!nxt_rd[SLOT_W]) begin
						prv_we = 1'b1;
						prv_wa = nxt_rd[SLOT_W-1:0];
						prv_wd = NULL_PTR;
					end
					stk_we = (fcount_q < (SLOT_W+1)'(FLOW_SLOTS));
				end
			end
			S_RM_HEAD: begin
				if (bkt_rd == {1'b0, vic_q}) begin
					bkt_we = 1'b1;
					bkt_wa = vb_q;
					bkt_wd = chn_rd;
				end else begin
					chn_ra = bkt_rd[SLOT_W-1:0];
				end
			end
			S_RM_WALK: begin
				if (chn_rd == {1'b0, vic_q}) begin
					chn_we = 1'b1;
					chn_wa = cur_q;
					chn_wd = vnext_q;
				end else begin
					chn_ra = chn_rd[SLOT_W-1:0];
				end
			end
			S_LOOK: bkt_ra = flow_hash(item_q.key);
			S_LK_HEAD: begin
				key_ra = bkt_rd[SLOT_W-1:0];
				chn_ra = bkt_rd[SLOT_W-1:0];
			end
			S_LK_CMP: begin
				key_ra = chn_rd[SLOT_W-1:0];
				chn_ra = chn_rd[SLOT_W-1:0];
			end
			S_HIT: begin
				prv_ra = slot_q;
				nxt_ra = slot_q;
			end
			S_RF_UNLINK: begin
				seen_we = 1'b1;
				if ({1'b0, slot_q} != newest_q) begin
					if (!prv_rd[SLOT_W]) begin
						nxt_we = 1'b1;
						nxt_wa = prv_rd[SLOT_W-1:0];
						nxt_wd = nxt_rd;
					end
					prv_we = 1'b1;
					prv_wa = nxt_rd[SLOT_W-1:0];
					prv_wd = prv_rd;
				end
			end
			S_AL_WR: begin
				key_we = 1'b1;
				seen_we = 1'b1;
				chn_we = 1'b1;
				bkt_we = 1'b1;
			end
			S_AP1: begin
				prv_we = 1'b1;
				prv_wd = newest_q;
				nxt_we = 1'b1;
				nxt_wd = NULL_PTR;
			end
			S_AP2: begin
				if (!newest_q[SLOT_W]) begin
					nxt_we = 1'b1;
					nxt_wa = newest_q[SLOT_W-1:0];
					nxt_wd = {1'b0, slot_q};
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_CLR;
			clr_q <= '0;
			oldest_q <= NULL_PTR;
			newest_q <= NULL_PTR;
			fcount_q <= '0;
			fresh_q <= '0;
			timeout_q <= TIMEOUT_RESET;
			out_vld_q <= 1'b0;
			out_verdict_q <= VERDICT_DROP;
			item_q <= '0;
			limit_q <= '0;
			can_exp_q <= 1'b0;
			hb_q <= '0;
			vb_q <= '0;
			vic_q <= '0;
			cur_q <= '0;
			slot_q <= '0;
			vnext_q <= NULL_PTR;
			head_q <= NULL_PTR;
			verdict_q <= VERDICT_DROP;
		end else begin
			if (cfg_we) timeout_q <= cfg_wdata;
			if (st_q == S_OUT && (!out_vld_q || res.ready)) out_vld_q <= 1'b1;
			else if (res.ready) out_vld_q <= 1'b0;
			case (st_q)
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BKT_W'(BUCKETS - 1)) st_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_vld) begin
						item_q <= q_item;
						can_exp_q <= (q_item.now >= tmo_ext);
						limit_q <= q_item.now - tmo_ext;
						st_q <= S_EXP_CHK;
					end
				end
				S_EXP_CHK: begin
					vic_q <= oldest_q[SLOT_W-1:0];
					st_q <= (can_exp_q && !oldest_q[SLOT_W]) ? S_EXP_WAIT : S_LOOK;
				end
				S_EXP_WAIT: begin
					if (release_now) begin
						vb_q <= flow_hash(key_rd);
						if (nxt_rd[SLOT_W]) begin
							oldest_q <= NULL_PTR;
							newest_q <= NULL_PTR;
						end else begin
							oldest_q <= nxt_rd;
						end
						if (fcount_q < (SLOT_W+1)'(FLOW_SLOTS)) fcount_q <= fcount_q + 1'b1;
						st_q <= S_RM_HEAD;
					end else begin
						st_q <= S_LOOK;
					end
				end
				S_RM_HEAD: begin
					vnext_q <= chn_rd;
					cur_q <= bkt_rd[SLOT_W-1:0];
					if (bkt_rd == {1'b0, vic_q} || bkt_rd[SLOT_W]) st_q <= S_EXP_CHK;
					else st_q <= S_RM_WALK;
				end
				S_RM_WALK: begin
					cur_q <= chn_rd[SLOT_W-1:0];
					if (chn_rd == {1'b0, vic_q} || chn_rd[SLOT_W]) st_q <= S_EXP_CHK;
				end
				S_LOOK: begin
					if (!item_q.ok) begin
						verdict_q <= VERDICT_DROP;
						st_q <= S_OUT;
					end else begin
						hb_q <= flow_hash(item_q.key);
						st_q <= S_LK_HEAD;
					end
				end
				S_LK_HEAD: begin
					head_q <= bkt_rd;
					cur_q <= bkt_rd[SLOT_W-1:0];
					st_q <= bkt_rd[SLOT_W] ? S_MISS : S_LK_CMP;
				end
				S_LK_CMP: begin
					if (key_rd == item_q.key) begin
						slot_q <= cur_q;
						st_q <= S_HIT;
					end else if (chn_rd[SLOT_W]) begin
						st_q <= S_MISS;
					end else begin
						cur_q <= chn_rd[SLOT_W-1:0];
					end
				end
				S_HIT: begin
					verdict_q <= item_q.is_wan ? VERDICT_LAN : VERDICT_WAN;
					st_q <= S_RF_UNLINK;
				end
				S_RF_UNLINK: begin
					if ({1'b0, slot_q} == newest_q) begin
						st_q <= S_OUT;
					end else begin
						if (prv_rd[SLOT_W]) oldest_q <= nxt_rd;
						st_q <= S_AP1;
					end
				end
				S_MISS: begin
					if (item_q.is_wan) begin
						verdict_q <= VERDICT_DROP;
						st_q <= S_OUT;
					end else begin
						verdict_q <= VERDICT_WAN;
						if (fcount_q != '0) begin
							fcount_q <= fdec;
							st_q <= S_AL_POP;
						end else if (fresh_q < (SLOT_W+1)'(FLOW_SLOTS)) begin
							// slots never used yet are handed out in order
							slot_q <= fresh_q[SLOT_W-1:0];
							fresh_q <= fresh_q + 1'b1;
							st_q <= S_AL_WR;
						end else begin
							st_q <= S_OUT;
						end
					end
				end
				S_AL_POP: begin
					slot_q <= stk_rd;
					st_q <= S_AL_WR;
				end
				S_AL_WR: st_q <= S_AP1;
				S_AP1: st_q <= S_AP2;
				S_AP2: begin
					if (newest_q[SLOT_W]) oldest_q <= {1'b0, slot_q};
					newest_q <= {1'b0, slot_q};
					st_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_vld_q || res.ready) begin
						out_verdict_q <= verdict_q;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

### hw/rtl/sffa_checker.sv
`timescale 1ns / 1ps
`include "stateful_flow_firewall_with_aging_defines.svh"
module sffa_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic res_valid,
	input logic res_ready,
	input logic [1:0] res_verdict
);
	import sffa_pkg::*;

	logic [2:0] pend_q;
	logic in_acc, out_acc;

	assign in_acc = in_valid && in_ready;
	assign out_acc = res_valid && res_ready;

	// transactions taken in but not yet answered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) pend_q <= 3'd0;
		else pend_q <= pend_q + {2'b0, in_acc} - {2'b0, out_acc};
	end

	`SFFA_ASSERT(a_verdict_code, res_valid, res_verdict == VERDICT_DROP || res_verdict == VERDICT_LAN || res_verdict == VERDICT_WAN, "bad verdict code")
	`SFFA_ASSERT(a_no_invented, res_valid, pend_q != 3'd0, "verdict without packet")
	`SFFA_ASSERT(a_bounded, in_acc, pend_q <= 3'd3, "too many packets in flight")
	`SFFA_ASSERT_NX(a_hold, res_valid && !res_ready, res_valid && $stable(res_verdict), "verdict dropped while stalled")
endmodule

bind stateful_flow_firewall_with_aging sffa_checker u_sffa_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(pkt.valid), .in_ready(pkt.ready),
	.res_valid(res.valid), .res_ready(res.ready), .res_verdict(res.verdict)
);

### tb/tb.sv
`timescale 1ns / 1ps
module tb;
	import sffa_pkg::*;

	localparam int CYCLE_LIMIT = 700000;
	localparam logic [62:0] TIME_MAX = 63'h7FFF_FFFF_FFFF_FFFF;

	typedef struct {
		logic from_wan;
		logic l4_valid;
		logic [31:0] src_ip;
		logic [31:0] dst_ip;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [62:0] now_ns;
	} packet_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;

	sffa_pkt_if pkt_bus();
	sffa_verdict_if res_bus();

	stateful_flow_firewall_with_aging uut (
		.clk(clk),
		.arst_n(arst_n),
		.pkt(pkt_bus),
		.res(res_bus),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// flow table mirror: last refresh per key, keys ordered oldest first
	logic [62:0] flow_seen [logic [95:0]];
	logic [95:0] age_order[$];
	logic [31:0] timeout_ns = TIMEOUT_RESET;

	packet_t pending_pkts[$];
	packet_t on_wire;
	logic [1:0] verdict_q[$];
	int errors = 0;
	int gap_left = 0;
	int stall_left = 0;
	int hold_left = 0;
	int idle_pct = 10;
	int verdicts_seen = 0;
	bit hold_done = 0;
	bit quiet = 0;
	int cycles = 0;
	logic [63:0] cur_now;

	logic [31:0] pool_src [10];
	logic [31:0] pool_dst [10];
	logic [15:0] pool_sp [10];
	logic [15:0] pool_dp [10];

	initial clk = 0;
	always #10 clk = ~clk;

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	function automatic void flow_touch(logic [95:0] key, logic [62:0] now);
		int idx[$];
		idx = age_order.find_first_index(k) with (k == key);
		if (idx.size() > 0) age_order.delete(idx[0]);
		age_order.push_back(key);
		flow_seen[key] = now;
	endfunction

	function automatic logic [1:0] firewall_verdict(packet_t p);
		logic [62:0] lim;
		logic [95:0] key;
		if (p.now_ns >= {31'd0, timeout_ns}) begin
			lim = p.now_ns - {31'd0, timeout_ns};
			while (age_order.size() > 0 && flow_seen[age_order[0]] < lim) begin
				flow_seen.delete(age_order[0]);
				void'(age_order.pop_front());
			end
		end
		if (!p.l4_valid) return VERDICT_DROP;
		if (!p.from_wan) begin
			key = {p.src_ip, p.dst_ip, p.sport, p.dport};
			// a full table still forwards, it just records nothing
			if (flow_seen.exists(key) || age_order.size() < FLOW_SLOTS)
				flow_touch(key, p.now_ns);
			return VERDICT_WAN;
		end
		key = {p.dst_ip, p.src_ip, p.dport, p.sport};
		if (!flow_seen.exists(key)) return VERDICT_DROP;
		flow_touch(key, p.now_ns);
		return VERDICT_LAN;
	endfunction

	task automatic add_pkt(input logic wan, input logic ok, input logic [31:0] s,
		input logic [31:0] d, input logic [15:0] sp, input logic [15:0] dp,
		input logic [62:0] now);
		packet_t p;
		p.from_wan = wan;
		p.l4_valid = ok;
		p.src_ip = s;
		p.dst_ip = d;
		p.sport = sp;
		p.dport = dp;
		p.now_ns = now;
		pending_pkts.push_back(p);
	endtask

	task automatic advance_time();
		logic [63:0] t;
		int r;
		t = {32'd0, timeout_ns};
		r = $urandom_range(0, 99);
		if (r < 5) begin
			cur_now = cur_now + t + $urandom_range(1, 3);
		end else if (r < 8) begin
			// time going backwards a little
			if (cur_now > 64'd5) cur_now = cur_now - $urandom_range(1, 5);
		end else begin
			cur_now = cur_now + $urandom_range(0, 3) * (t / 6 + 1);
		end
		cur_now[63] = 1'b0;
	endtask

	task automatic random_phase(input int count);
		int r;
		int f;
		for (int i = 0; i < 10; i++) begin
			pool_src[i] = $urandom;
			pool_dst[i] = $urandom;
			pool_sp[i] = 16'($urandom);
			pool_dp[i] = 16'($urandom);
		end
		for (int i = 0; i < count; i++) begin
			advance_time();
			r = $urandom_range(0, 99);
			f = $urandom_range(0, 9);
			if (r < 10)
				add_pkt(1'($urandom), 1'b0, pool_src[f], pool_dst[f], pool_sp[f], pool_dp[f],
					cur_now[62:0]);
			else if (r < 50)
				add_pkt(1'b0, 1'b1, pool_src[f], pool_dst[f], pool_sp[f], pool_dp[f],
					cur_now[62:0]);
			else if (r < 85)
				add_pkt(1'b1, 1'b1, pool_dst[f], pool_src[f], pool_dp[f], pool_sp[f],
					cur_now[62:0]);
			else
				add_pkt(1'($urandom), 1'b1, $urandom, $urandom, 16'($urandom),
					16'($urandom), cur_now[62:0]);
		end
	endtask

	task automatic settle_and_write(input logic [31:0] value, input int pct);
		while (pending_pkts.size() > 0 || verdict_q.size() > 0 || pkt_bus.valid)
			@(posedge clk);
		repeat (30) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		timeout_ns = value;
		idle_pct = pct;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (pkt_bus.valid && pkt_bus.ready)
				verdict_q.push_back(firewall_verdict(on_wire));
			if (!(pkt_bus.valid && !pkt_bus.ready)) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					pkt_bus.valid <= 1'b0;
				end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
					gap_left <= $urandom_range(0, 17);
					pkt_bus.valid <= 1'b0;
				end else if (pending_pkts.size() > 0) begin
					on_wire = pending_pkts.pop_front();
					pkt_bus.valid <= 1'b1;
					pkt_bus.from_wan <= on_wire.from_wan;
					pkt_bus.l4_valid <= on_wire.l4_valid;
					pkt_bus.src_ip <= on_wire.src_ip;
					pkt_bus.dst_ip <= on_wire.dst_ip;
					pkt_bus.src_l4_port <= on_wire.sport;
					pkt_bus.dst_l4_port <= on_wire.dport;
					pkt_bus.now_ns <= on_wire.now_ns;
				end else begin
					pkt_bus.valid <= 1'b0;
				end
			end
		end
	end

	// long receiver hold so the input side backs up
	always @(posedge clk) begin
		if (hold_left > 0)
			hold_left <= hold_left - 1;
		else if (!hold_done && verdicts_seen == 150) begin
			hold_left <= 600;
			hold_done <= 1'b1;
		end
	end

	// receiver and checker
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_bus.valid && res_bus.ready) begin
				verdicts_seen <= verdicts_seen + 1;
				if (verdict_q.size() == 0)
					report($sformatf("verdict %0d with nothing expected", res_bus.verdict));
				else if (res_bus.verdict !== verdict_q[0])
					report($sformatf("verdict %0d, expected %0d", res_bus.verdict,
						verdict_q.pop_front()));
				else
					void'(verdict_q.pop_front());
			end
			if (quiet)
				res_bus.ready <= 1'b1;
			else if (hold_left > 0)
				res_bus.ready <= 1'b0;
			else if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				res_bus.ready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				stall_left <= $urandom_range(0, 17);
				res_bus.ready <= 1'b0;
			end else
				res_bus.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		pkt_bus.valid = 1'b0;
		pkt_bus.from_wan = 1'b0;
		pkt_bus.l4_valid = 1'b0;
		pkt_bus.src_ip = '0;
		pkt_bus.dst_ip = '0;
		pkt_bus.src_l4_port = '0;
		pkt_bus.dst_l4_port = '0;
		pkt_bus.now_ns = '0;
		res_bus.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n = 1'b1;

		// directed: unknown reply, invalid, new flow, reply, refresh, extremes, aging
		add_pkt(1'b1, 1'b1, 32'h0A000001, 32'hC0A80001, 16'd80, 16'd1234, 63'd0);
		add_pkt(1'b0, 1'b0, 32'hC0A80001, 32'h0A000001, 16'd1234, 16'd80, 63'd0);
		add_pkt(1'b0, 1'b1, 32'hC0A80001, 32'h0A000001, 16'd1234, 16'd80, 63'd10);
		add_pkt(1'b1, 1'b1, 32'h0A000001, 32'hC0A80001, 16'd80, 16'd1234, 63'd20);
		add_pkt(1'b1, 1'b0, 32'h0A000001, 32'hC0A80001, 16'd80, 16'd1234, 63'd25);
		add_pkt(1'b0, 1'b1, 32'hC0A80001, 32'h0A000001, 16'd1234, 16'd80, 63'd30);
		add_pkt(1'b0, 1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 63'd40);
		add_pkt(1'b0, 1'b1, '1, '1, '1, '1, 63'd50);
		add_pkt(1'b1, 1'b1, '1, '1, '1, '1, 63'd60);
		add_pkt(1'b1, 1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 63'd70);
		// time steps back, flow still there
		add_pkt(1'b1, 1'b1, 32'h0A000001, 32'hC0A80001, 16'd80, 16'd1234, 63'd5);
		// just at the boundary, then past it
		add_pkt(1'b1, 1'b1, '1, '1, '1, '1, 63'd1000000060);
		add_pkt(1'b1, 1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 63'd1000000071);
		add_pkt(1'b1, 1'b1, '1, '1, '1, '1, 63'd3000000000);
		add_pkt(1'b0, 1'b1, 32'h0A0B0C0D, 32'h01020304, 16'hFFFF, 16'h0001, 63'd3000000001);
		cur_now = 64'd3000000001;
		random_phase(90);

		// zero timeout: anything older than now goes
		settle_and_write(32'd0, 10);
		random_phase(100);

		settle_and_write(32'd1, 25);
		random_phase(100);

		settle_and_write(32'hFFFF_FFFF, 5);
		cur_now = {1'b0, 31'($urandom), 32'($urandom)} >> 2;
		random_phase(100);

		settle_and_write($urandom_range(1000, 100000), 0);
		random_phase(100);

		// near the top of the time range, no idling on either side
		settle_and_write(TIMEOUT_RESET, 0);
		quiet = 1'b1;
		cur_now = {1'b0, TIME_MAX} - 64'd200_000_000_000;
		random_phase(100);
		add_pkt(1'b0, 1'b1, pool_src[0], pool_dst[0], pool_sp[0], pool_dp[0], TIME_MAX);
		add_pkt(1'b1, 1'b1, pool_dst[0], pool_src[0], pool_dp[0], pool_sp[0], TIME_MAX);

		while (pending_pkts.size() > 0 || verdict_q.size() > 0 || pkt_bus.valid)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
